FILE: rtl/gdo_pkg.sv
package gdo_pkg;

  // default upper year limit
  localparam int unsigned MAX_YEAR_DEF = 9999;

  // field widths
  localparam int YEAR_IN_W  = 14;
  localparam int MONTH_W    = 4;
  localparam int DAY_W      = 5;
  localparam int OFFSET_W   = 17;
  localparam int ORD_W      = 9;
  // running day index: covers ordinal plus or minus the largest offset
  localparam int T_W        = 18;
  // wide compare width for years up to the parameter's top value
  localparam int YEAR_CMP_W = 17;

  // position in the 400-year leap cycle
  localparam int CYC_W = 9;
  localparam logic [CYC_W-1:0] CYCLE_LEN = 9'd400;
  // restoring reduction: subtract 400 << k for k = MOD_STEPS-1 down to 0
  localparam int MOD_STEPS = 6;
  localparam int SHIFT_W   = 3;

  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTHS    = 4'd12;

  // commands from controller to datapath
  typedef struct packed {
    logic               load;
    logic               mod_step;
    logic [SHIFT_W-1:0] mod_shift;
    logic               check;
    logic               year_step;
    logic               month_step;
    logic               finish;
    logic               oor;
  } gdo_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic valid;
    logic year_oor;
    logic year_fit;
    logic month_done;
  } gdo_stat_t;

  // leap test on the year's position in the 400-year cycle
  function automatic logic leap_of(input logic [CYC_W-1:0] c);
    return (c[1:0] == 2'b00) && (c != 9'd100) && (c != 9'd200) && (c != 9'd300);
  endfunction

  function automatic logic [DAY_W-1:0] days_in_month(input logic leap,
                                                     input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    if (m == MONTH_FEB) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      len = 5'd30;
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

  // days before the first of month m in a common year
  function automatic logic [ORD_W-1:0] cum_before(input logic [MONTH_W-1:0] m);
    logic [ORD_W-1:0] c;
    case (m)
      4'd1:    c = 9'd0;
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

  function automatic logic [ORD_W-1:0] year_len(input logic leap);
    return leap ? 9'd366 : 9'd365;
  endfunction

endpackage

FILE: rtl/gdo_ctrl.sv
module gdo_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  output gdo_pkg::gdo_cmd_t  cmd,
  input  gdo_pkg::gdo_stat_t stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_CHECK,
    S_YEAR,
    S_MONTH
  } state_t;

  state_t                       state;
  logic [gdo_pkg::SHIFT_W-1:0]  step;

  assign busy = (state != S_IDLE);

  // command decode
  always_comb begin
    cmd           = '0;
    cmd.mod_shift = step;
    case (state)
      S_IDLE:  cmd.load = start;
      S_MOD:   cmd.mod_step = 1'b1;
      S_CHECK: cmd.check = 1'b1;
      S_YEAR: begin
        if (!stat.valid) begin
          cmd.finish = 1'b1;
        end else if (stat.year_oor) begin
          cmd.finish = 1'b1;
          cmd.oor    = 1'b1;
        end else if (!stat.year_fit) begin
          cmd.year_step = 1'b1;
        end
      end
      S_MONTH: begin
        if (stat.month_done) begin
          cmd.finish = 1'b1;
        end else begin
          cmd.month_step = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

  // state and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      done  <= 1'b0;
    end else begin
      done <= cmd.finish;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_MOD;
            step  <= gdo_pkg::SHIFT_W'(gdo_pkg::MOD_STEPS - 1);
          end
        end
        S_MOD: begin
          if (step == '0) begin
            state <= S_CHECK;
          end else begin
            step <= step - 1'b1;
          end
        end
        S_CHECK: state <= S_YEAR;
        S_YEAR: begin
          if (!stat.valid || stat.year_oor) begin
            state <= S_IDLE;
          end else if (stat.year_fit) begin
            state <= S_MONTH;
          end
        end
        S_MONTH: begin
          if (stat.month_done) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/gdo_datapath.sv
module gdo_datapath #(
  parameter int unsigned MaxYear = gdo_pkg::MAX_YEAR_DEF
) (
  input  logic                              clk,
  input  logic [gdo_pkg::YEAR_IN_W-1:0]     in_year,
  input  logic [gdo_pkg::MONTH_W-1:0]       in_month,
  input  logic [gdo_pkg::DAY_W-1:0]         in_day,
  input  logic signed [gdo_pkg::OFFSET_W-1:0] day_offset,
  input  gdo_pkg::gdo_cmd_t                 cmd,
  output gdo_pkg::gdo_stat_t                stat,
  output logic                              date_valid,
  output logic                              is_leap,
  output logic [gdo_pkg::ORD_W-1:0]         ordinal_day,
  output logic [gdo_pkg::YEAR_IN_W-1:0]     out_year,
  output logic [gdo_pkg::MONTH_W-1:0]       out_month,
  output logic [gdo_pkg::DAY_W-1:0]         out_day,
  output logic                              out_of_range
);

  localparam int YEAR_W = $clog2(MaxYear + 1);
  localparam logic [gdo_pkg::YEAR_CMP_W-1:0] MAX_Y = gdo_pkg::YEAR_CMP_W'(MaxYear);
  localparam int T_W = gdo_pkg::T_W;

  // captured input date
  logic [gdo_pkg::YEAR_IN_W-1:0] yr_in;
  logic [gdo_pkg::MONTH_W-1:0]   mo_in;
  logic [gdo_pkg::DAY_W-1:0]     dy_in;
  logic [gdo_pkg::OFFSET_W-1:0]  off_in;

  // working registers
  logic [gdo_pkg::YEAR_IN_W-1:0] rem;
  logic [gdo_pkg::CYC_W-1:0]     cyc;
  logic [YEAR_W-1:0]             yr;
  logic [gdo_pkg::MONTH_W-1:0]   mo;
  logic [T_W-1:0]                t;
  logic                          valid_r;
  logic                          leap_r;
  logic [gdo_pkg::ORD_W-1:0]     ord_r;

  logic [gdo_pkg::YEAR_IN_W-1:0] mod_sub;
  logic                          in_leap;
  logic                          in_valid;
  logic [gdo_pkg::ORD_W-1:0]     in_ord;
  logic [T_W-1:0]                t_init;
  logic [gdo_pkg::CYC_W-1:0]     cyc_inc;
  logic [gdo_pkg::CYC_W-1:0]     cyc_dec;
  logic [gdo_pkg::ORD_W-1:0]     len_cur;
  logic [gdo_pkg::ORD_W-1:0]     len_prev;
  logic [gdo_pkg::DAY_W-1:0]     mdays;
  logic                          neg;
  logic                          over;
  logic                          echo;

  // year mod 400 reduction step
  assign mod_sub = gdo_pkg::YEAR_IN_W'(gdo_pkg::CYCLE_LEN) << cmd.mod_shift;

  // legality, leap and ordinal of the input date
  assign in_leap  = gdo_pkg::leap_of(rem[gdo_pkg::CYC_W-1:0]);
  assign in_valid = (yr_in != '0) && (gdo_pkg::YEAR_CMP_W'(yr_in) <= MAX_Y) &&
                    (mo_in != '0) && (mo_in <= gdo_pkg::MONTHS) &&
                    (dy_in != '0) && (dy_in <= gdo_pkg::days_in_month(in_leap, mo_in));
  assign in_ord   = gdo_pkg::cum_before(mo_in) + gdo_pkg::ORD_W'(dy_in) +
                    gdo_pkg::ORD_W'(in_leap && (mo_in > gdo_pkg::MONTH_FEB));
  assign t_init   = {{(T_W - gdo_pkg::ORD_W){1'b0}}, in_ord} +
                    {{(T_W - gdo_pkg::OFFSET_W){off_in[gdo_pkg::OFFSET_W-1]}}, off_in} -
                    T_W'(1);

  // year walk
  assign cyc_inc  = (cyc == gdo_pkg::CYCLE_LEN - 1'b1) ? '0 : cyc + 1'b1;
  assign cyc_dec  = (cyc == '0) ? gdo_pkg::CYCLE_LEN - 1'b1 : cyc - 1'b1;
  assign len_cur  = gdo_pkg::year_len(gdo_pkg::leap_of(cyc));
  assign len_prev = gdo_pkg::year_len(gdo_pkg::leap_of(cyc_dec));
  assign neg      = t[T_W-1];
  assign over     = !neg && (t >= T_W'(len_cur));

  // month walk
  assign mdays = gdo_pkg::days_in_month(gdo_pkg::leap_of(cyc), mo);

  // status
  assign stat.valid      = valid_r;
  assign stat.year_oor   = (neg && (yr == YEAR_W'(1))) ||
                           (over && (gdo_pkg::YEAR_CMP_W'(yr) == MAX_Y));
  assign stat.year_fit   = !neg && !over;
  assign stat.month_done = (mo == gdo_pkg::MONTHS) || (t < T_W'(mdays));

  assign echo = !valid_r || cmd.oor;

  always_ff @(posedge clk) begin
    // capture on transfer
    if (cmd.load) begin
      yr_in  <= in_year;
      mo_in  <= in_month;
      dy_in  <= in_day;
      off_in <= day_offset;
      rem    <= in_year;
    end
    if (cmd.mod_step && (rem >= mod_sub)) begin
      rem <= rem - mod_sub;
    end
    // check and set up the walk
    if (cmd.check) begin
      leap_r  <= in_leap;
      valid_r <= in_valid;
      ord_r   <= in_valid ? in_ord : '0;
      cyc     <= rem[gdo_pkg::CYC_W-1:0];
      yr      <= YEAR_W'(yr_in);
      mo      <= 4'd1;
      t       <= t_init;
    end
    // one year per step, either direction
    if (cmd.year_step) begin
      if (neg) begin
        yr  <= yr - 1'b1;
        cyc <= cyc_dec;
        t   <= t + T_W'(len_prev);
      end else begin
        yr  <= yr + 1'b1;
        cyc <= cyc_inc;
        t   <= t - T_W'(len_cur);
      end
    end
    if (cmd.month_step) begin
      mo <= mo + 1'b1;
      t  <= t - T_W'(mdays);
    end
    // result registers
    if (cmd.finish) begin
      date_valid   <= valid_r;
      is_leap      <= leap_r;
      ordinal_day  <= ord_r;
      out_of_range <= cmd.oor;
      out_year     <= echo ? yr_in : gdo_pkg::YEAR_IN_W'(yr);
      out_month    <= echo ? mo_in : mo;
      out_day      <= echo ? dy_in : t[gdo_pkg::DAY_W-1:0] + 1'b1;
    end
  end

endmodule

FILE: rtl/gregorian_date_offset_top.sv
// Gregorian date offset: a transfer is taken when start is high and busy is low;
// the block then checks the date, finds its leap flag and day of year, and walks
// to the date day_offset days away. It works on one date at a time. After the
// transfer, the block reduces the year modulo 400, checks the date, then walks
// the years one at a time and then the months one at a time; the result is
// registered. An illegal date finishes after the check, with no walk. Each
// result is on the output ports for exactly one cycle with done high; the
// receiver cannot stall, so it must take the result in that cycle. The outputs
// hold their values until the next result.
module gregorian_date_offset_top #(
  parameter int unsigned MaxYear = gdo_pkg::MAX_YEAR_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [gdo_pkg::YEAR_IN_W-1:0]       in_year,
  input  logic [gdo_pkg::MONTH_W-1:0]         in_month,
  input  logic [gdo_pkg::DAY_W-1:0]           in_day,
  input  logic signed [gdo_pkg::OFFSET_W-1:0] day_offset,
  output logic                                done,
  output logic                                date_valid,
  output logic                                is_leap,
  output logic [gdo_pkg::ORD_W-1:0]           ordinal_day,
  output logic [gdo_pkg::YEAR_IN_W-1:0]       out_year,
  output logic [gdo_pkg::MONTH_W-1:0]         out_month,
  output logic [gdo_pkg::DAY_W-1:0]           out_day,
  output logic                                out_of_range
);

  gdo_pkg::gdo_cmd_t  cmd;
  gdo_pkg::gdo_stat_t stat;

  gdo_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .stat  (stat)
  );

  gdo_datapath #(
    .MaxYear (MaxYear)
  ) u_datapath (
    .clk          (clk),
    .in_year      (in_year),
    .in_month     (in_month),
    .in_day       (in_day),
    .day_offset   (day_offset),
    .cmd          (cmd),
    .stat         (stat),
    .date_valid   (date_valid),
    .is_leap      (is_leap),
    .ordinal_day  (ordinal_day),
    .out_year     (out_year),
    .out_month    (out_month),
    .out_day      (out_day),
    .out_of_range (out_of_range)
  );

endmodule

FILE: rtl/gdo_checker.sv
module gdo_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                start,
  input logic                                busy,
  input logic [gdo_pkg::YEAR_IN_W-1:0]       in_year,
  input logic [gdo_pkg::MONTH_W-1:0]         in_month,
  input logic [gdo_pkg::DAY_W-1:0]           in_day,
  input logic signed [gdo_pkg::OFFSET_W-1:0] day_offset,
  input logic                                done,
  input logic                                date_valid,
  input logic                                is_leap,
  input logic [gdo_pkg::ORD_W-1:0]           ordinal_day,
  input logic [gdo_pkg::YEAR_IN_W-1:0]       out_year,
  input logic [gdo_pkg::MONTH_W-1:0]         out_month,
  input logic [gdo_pkg::DAY_W-1:0]           out_day,
  input logic                                out_of_range
);

  // a transfer starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("no busy after transfer");

  // a result only ends a job
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("result strobe without job");

  // illegal date reports no ordinal and no range fault
  a_invalid_clean: assert property (@(posedge clk) disable iff (rst)
    done && !date_valid |-> !out_of_range && (ordinal_day == '0))
    else $error("illegal date result inconsistent");

  // a valid result has a nonzero ordinal, year and day and a month from 1 to 12
  a_valid_result: assert property (@(posedge clk) disable iff (rst)
    done && date_valid |-> (ordinal_day != '0) && (out_month != '0) &&
      (out_month <= gdo_pkg::MONTHS) && (out_day != '0) && (out_year != '0))
    else $error("valid result out of calendar");

endmodule

bind gregorian_date_offset_top gdo_checker u_gdo_checker (.*);
